FILE: hdl/bbs_pkg.sv
// Shared types and constants of the 3x3 box blur stream block.
package bbs_pkg;

  // Result queue depth in entries; one entry holds all results of one pixel.
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  // Entries kept free so that the pixels in flight always find room.
  localparam int QRESERVE = 4;

  // Divide by nine as a multiply by ceil(2^16 / 9) and a shift by 16.
  // This is exact for every window sum below 32768.
  localparam int SUMW       = 12;
  localparam int MEAN_SHIFT = 16;
  localparam int MEAN_MULW  = 13;
  localparam logic [MEAN_MULW-1:0] MEAN_MUL = 13'd7282;
  localparam int PRODW      = SUMW + MEAN_MULW;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // All results caused by one input pixel.
  typedef struct packed {
    logic        has_int;
    logic        has_bord;
    logic        eof;
    logic [11:0] int_row;
    logic [9:0]  int_col;
    logic [7:0]  mean;
    logic [11:0] row;
    logic [9:0]  col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic room;
    logic nonempty;
  } fifo_stat_t;

endpackage

FILE: hdl/bbs_front.sv
// Front part: pixel position tracking, line stores, window and window sum.
module bbs_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [10:0]          frame_width,
  input  logic [11:0]          frame_height,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_red,
  input  bbs_pkg::fifo_stat_t  q_stat,
  output logic                 push,
  output bbs_pkg::entry_t      push_entry
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [CW-1:0] col_count;
  logic [11:0]   row_count;

  logic [EW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [CW-1:0] c;
  logic [11:0]   r;
  logic [12:0]   r_step;
  logic [EW-1:0] c_plus;
  logic          accept;

  // Effective frame size after the zero and maximum width rules.
  always_comb begin
    if (frame_width == 11'd0) begin
      w_eff = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(frame_width);
    end
    h_eff = (frame_height == 12'd0) ? 12'd1 : frame_height;
  end

  // Position of the arriving pixel, also after a mid-frame size change.
  always_comb begin
    c = col_count;
    r_step = {1'b0, row_count};
    if (EW'(col_count) >= w_eff) begin
      c = '0;
      r_step = {1'b0, row_count} + 13'd1;
    end
    r = (r_step >= {1'b0, h_eff}) ? 12'd0 : r_step[11:0];
    c_plus = EW'(c) + EW'(1);
  end

  assign in_ready = q_stat.room && !rst;
  assign accept   = in_valid && in_ready;

  // Position counters for the next pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (c_plus >= w_eff) begin
        col_count <= '0;
        row_count <= ({1'b0, r} + 13'd1 >= {1'b0, h_eff}) ? 12'd0 : r + 12'd1;
      end else begin
        col_count <= CW'(c_plus);
        row_count <= r;
      end
    end
  end

  // Stage one: pixel with its classification, line store data arrives.
  logic          s1_valid;
  logic [CW-1:0] s1_c;
  logic          s1_fwd;
  logic          s1_r1;
  logic          s1_r2;
  logic          s1_int;
  logic          s1_bord;
  logic          s1_eof;
  logic [11:0]   s1_row;
  logic [9:0]    s1_col;
  logic [11:0]   s1_irow;
  logic [9:0]    s1_icol;
  logic [7:0]    s1_blue;
  logic [7:0]    s1_green;
  logic [7:0]    s1_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c     <= c;
      s1_fwd   <= s1_valid && (s1_c == c);
      s1_r1    <= (r >= 12'd1);
      s1_r2    <= (r >= 12'd2);
      s1_int   <= (r >= 12'd2) && (c >= CW'(2));
      s1_bord  <= (r == 12'd0) || (r == h_eff - 12'd1) || (c == '0) ||
                  (EW'(c) == w_eff - EW'(1));
      s1_eof   <= (r == h_eff - 12'd1) && (EW'(c) == w_eff - EW'(1));
      s1_row   <= r;
      s1_col   <= 10'(c);
      s1_irow  <= r - 12'd1;
      s1_icol  <= 10'(c) - 10'd1;
      s1_blue  <= in_blue;
      s1_green <= in_green;
      s1_red   <= in_red;
    end
  end

  // Line stores: read at the arriving column, written back from stage one.
  logic [7:0] older_mem [MAX_WIDTH];
  logic [7:0] newer_mem [MAX_WIDTH];
  logic [7:0] older_q;
  logic [7:0] newer_q;
  logic [7:0] last_older;
  logic [7:0] last_newer;
  logic [7:0] older_val;
  logic [7:0] newer_val;
  logic [7:0] top;
  logic [7:0] mid;

  // The previous pixel's write lands after a back-to-back read of its column.
  assign older_val = s1_fwd ? last_older : older_q;
  assign newer_val = s1_fwd ? last_newer : newer_q;
  assign top = s1_r2 ? older_val : 8'd0;
  assign mid = s1_r1 ? newer_val : 8'd0;

  always_ff @(posedge clk) begin
    if (accept) begin
      older_q <= older_mem[c];
    end
    if (s1_valid && s1_r1) begin
      older_mem[s1_c] <= newer_val;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      newer_q <= newer_mem[c];
    end
    if (s1_valid) begin
      newer_mem[s1_c] <= s1_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      last_older <= s1_r1 ? newer_val : older_val;
      last_newer <= s1_blue;
    end
  end

  // Window of the two previous columns for rows r-2, r-1 and r.
  logic [7:0] win [6];
  logic [bbs_pkg::SUMW-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= 8'd0;
      end
    end else if (s1_valid) begin
      win[1] <= win[0];
      win[0] <= top;
      win[3] <= win[2];
      win[2] <= mid;
      win[5] <= win[4];
      win[4] <= s1_blue;
    end
  end

  // Sum of the nine channel-zero values of the window.
  always_comb begin
    sum = bbs_pkg::SUMW'(top) + bbs_pkg::SUMW'(mid) + bbs_pkg::SUMW'(s1_blue);
    for (int i = 0; i < 6; i++) begin
      sum = sum + bbs_pkg::SUMW'(win[i]);
    end
  end

  // Stage two: divide the sum by nine and push the pixel's results.
  logic                     s2_valid;
  logic [bbs_pkg::SUMW-1:0] s2_sum;
  bbs_pkg::entry_t          s2_entry;
  logic [bbs_pkg::PRODW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1_int || s1_bord);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_sum            <= sum;
      s2_entry.has_int  <= s1_int;
      s2_entry.has_bord <= s1_bord;
      s2_entry.eof      <= s1_eof;
      s2_entry.int_row  <= s1_irow;
      s2_entry.int_col  <= s1_icol;
      s2_entry.mean     <= 8'd0;
      s2_entry.row      <= s1_row;
      s2_entry.col      <= s1_col;
      s2_entry.blue     <= s1_blue;
      s2_entry.green    <= s1_green;
      s2_entry.red      <= s1_red;
    end
  end

  assign prod = bbs_pkg::PRODW'(s2_sum) * bbs_pkg::PRODW'(bbs_pkg::MEAN_MUL);

  always_comb begin
    push_entry      = s2_entry;
    push_entry.mean = prod[bbs_pkg::MEAN_SHIFT +: 8];
  end

  assign push = s2_valid;

endmodule

FILE: hdl/bbs_fifo.sv
// Queue of per-pixel result entries between the front and the back.
module bbs_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bbs_pkg::entry_t     push_entry,
  input  logic                pop,
  output bbs_pkg::entry_t     head,
  output bbs_pkg::fifo_stat_t stat
);

  bbs_pkg::entry_t            mem [bbs_pkg::QDEPTH];
  logic [bbs_pkg::QAW-1:0]    wr_ptr;
  logic [bbs_pkg::QAW-1:0]    rd_ptr;
  logic [bbs_pkg::QAW:0]      count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  assign head          = mem[rd_ptr];
  assign stat.nonempty = (count != '0);
  assign stat.room     = (count <= (bbs_pkg::QAW+1)'(bbs_pkg::QDEPTH - bbs_pkg::QRESERVE));

endmodule

FILE: hdl/bbs_back.sv
// Back part: splits queue entries into single results behind an output register.
module bbs_back (
  input  logic                clk,
  input  logic                rst,
  input  bbs_pkg::entry_t     head,
  input  bbs_pkg::fifo_stat_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [11:0]         out_row,
  output logic [9:0]          out_col,
  output logic [7:0]          out_blue,
  output logic [7:0]          out_green,
  output logic [7:0]          out_red,
  output logic                last_of_item,
  output logic                end_of_frame
);

  bbs_pkg::entry_t cur;
  logic            cur_valid;
  logic            pend_int;
  logic            pend_bord;
  logic            load;
  logic            cur_done;

  // The output register takes a new result when empty or when taken.
  assign load     = !out_valid || out_ready;
  assign cur_done = !cur_valid || !(pend_int && pend_bord);
  assign pop      = load && cur_done && q_stat.nonempty;

  // Current entry and the results still owed from it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pend_int  <= 1'b0;
      pend_bord <= 1'b0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
        pend_int  <= head.has_int;
        pend_bord <= head.has_bord;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else begin
        pend_int <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Result payload: the interior mean first, then the border pixel.
  always_ff @(posedge clk) begin
    if (load && cur_valid) begin
      if (pend_int) begin
        out_row      <= cur.int_row;
        out_col      <= cur.int_col;
        out_blue     <= cur.mean;
        out_green    <= cur.mean;
        out_red      <= cur.mean;
        last_of_item <= !pend_bord;
        end_of_frame <= 1'b0;
      end else begin
        out_row      <= cur.row;
        out_col      <= cur.col;
        out_blue     <= cur.blue;
        out_green    <= cur.green;
        out_red      <= cur.red;
        last_of_item <= 1'b1;
        end_of_frame <= cur.eof;
      end
    end
  end

endmodule

FILE: hdl/box_blur_3x3_stream_top.sv
// Top level of the 3x3 box blur stream block: configuration and stream ports.
//
// Pixels enter in raster order at one per clock while the queue has room, and
// results leave at one per clock while the output is taken. Each interior
// pixel is replaced in all three channels by the truncated mean of the
// channel-0 values of its 3x3 neighborhood, and border pixels pass through;
// an interior result leaves just ahead of the border result of the pixel
// that completes its window, so one pixel may cause two results. The front
// part tracks the position, reads two line stores of MAX_WIDTH bytes and
// forms the window sum in two pipeline stages; a queue of eight per-pixel
// entries feeds the back part. The input stalls while the queue holds more
// than four entries, which happens when the output side is held back and
// along the last row of a frame, where most pixels cause two results.
module box_blur_3x3_stream_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_blue, in_green, in_red
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_row, out_col, out_blue, out_green, out_red, zero fill
  output logic        m_tlast,   // end_of_frame
  output logic [0:0]  m_tuser    // last_of_item
);

  logic [10:0] frame_width;
  logic [11:0] frame_height;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        bbs_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        bbs_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bbs_pkg::fifo_stat_t q_stat;
  bbs_pkg::entry_t     push_entry;
  bbs_pkg::entry_t     head;
  logic                push;
  logic                pop;

  bbs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_blue      (s_tdata[7:0]),
    .in_green     (s_tdata[15:8]),
    .in_red       (s_tdata[23:16]),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  bbs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        last_of_item;
  logic        end_of_frame;

  bbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .last_of_item (last_of_item),
    .end_of_frame (end_of_frame)
  );

  // Output packing, first field in the lowest bits.
  assign m_tdata    = {2'b00, out_red, out_green, out_blue, out_col, out_row};
  assign m_tlast    = end_of_frame;
  assign m_tuser[0] = last_of_item;

endmodule
